// File: rtl/a2u_pkg.sv
// Shared types and constants for the ASCII-to-unsigned parser.
package a2u_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned OUT_W       = 32;
  localparam int unsigned RADIX_W     = 6;
  localparam int unsigned CHR_W       = 8;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned DIGIT_W     = 7;
  localparam int unsigned PROD_W      = VALUE_WIDTH + RADIX_W;

  localparam logic [CHR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHR_W-1:0] CH_X_LO  = 8'h78;
  localparam logic [CHR_W-1:0] CH_X_UP  = 8'h58;

  localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 7'd64;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_SPACE  = 6'b000010,
    PH_SIGNED = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_HEX    = 6'b010000,
    PH_DIGITS = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    DS_NONE = 2'd0,
    DS_SOME = 2'd1,
    DS_OVER = 2'd2
  } dstat_e;

  typedef struct packed {
    logic               start_req;
    logic [RADIX_W-1:0] radix;
    logic [CHR_W-1:0]   chr;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             overflowed;
    logic             any_digits;
    logic [POS_W-1:0] end_offset;
  } out_t;

  typedef struct packed {
    phase_e                 phase;
    logic                   negative;
    logic [VALUE_WIDTH-1:0] accumulator;
    dstat_e                 digit_status;
    logic [RADIX_W-1:0]     active_base;
    logic [POS_W-1:0]       position;
  } state_t;

endpackage

// File: rtl/a2u_step.sv
// Next-state and result logic for one character of the parser.
module a2u_step (
  input  a2u_pkg::state_t state_i,
  input  a2u_pkg::in_t    req_i,
  output a2u_pkg::state_t state_o,
  output logic            emit_o,
  output a2u_pkg::out_t   res_o
);

  function automatic logic [a2u_pkg::DIGIT_W-1:0] digit_of(input logic [a2u_pkg::CHR_W-1:0] c);
    logic [a2u_pkg::DIGIT_W-1:0] d;
    d = a2u_pkg::DIGIT_NONE;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = a2u_pkg::DIGIT_W'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = a2u_pkg::DIGIT_W'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      d = a2u_pkg::DIGIT_W'(c - 8'h41 + 8'd10);
    end
    return d;
  endfunction

  a2u_pkg::state_t               st;
  logic                          go;
  logic                          num_first;
  logic                          do_take;
  logic [a2u_pkg::DIGIT_W-1:0]   dig;
  logic [a2u_pkg::PROD_W-1:0]    prod;
  logic [a2u_pkg::VALUE_WIDTH-1:0] v;
  logic [a2u_pkg::CHR_W-1:0]     c;

  always_comb begin
    st        = state_i;
    go        = 1'b1;
    num_first = 1'b0;
    do_take   = 1'b0;
    emit_o    = 1'b0;
    v         = '0;
    c         = req_i.chr;
    dig       = digit_of(c);
    prod      = '0;

    if (req_i.start_req) begin
      st.phase        = a2u_pkg::PH_SPACE;
      st.negative     = 1'b0;
      st.accumulator  = '0;
      st.digit_status = a2u_pkg::DS_NONE;
      st.active_base  = req_i.radix;
      st.position     = '0;
    end else if (st.phase == a2u_pkg::PH_IDLE) begin
      go = 1'b0;
    end else if (st.position != '1) begin
      st.position = st.position + 1'b1;
    end

    if (go) begin
      unique case (st.phase)
        a2u_pkg::PH_SPACE: begin
          if (c == a2u_pkg::CH_SPACE) begin
            st.phase = a2u_pkg::PH_SPACE;
          end else if (c == a2u_pkg::CH_MINUS || c == a2u_pkg::CH_PLUS) begin
            st.negative = (c == a2u_pkg::CH_MINUS);
            st.phase    = a2u_pkg::PH_SIGNED;
          end else begin
            num_first = 1'b1;
          end
        end
        a2u_pkg::PH_SIGNED: num_first = 1'b1;
        a2u_pkg::PH_ZERO: begin
          if (c == a2u_pkg::CH_X_LO || c == a2u_pkg::CH_X_UP) begin
            st.active_base = a2u_pkg::RADIX_HEX;
            st.phase       = a2u_pkg::PH_HEX;
          end else begin
            if (st.active_base == a2u_pkg::RADIX_AUTO) st.active_base = a2u_pkg::RADIX_OCT;
            // leading zero counts as a digit of value zero
            st.digit_status = a2u_pkg::DS_SOME;
            do_take         = 1'b1;
          end
        end
        a2u_pkg::PH_HEX, a2u_pkg::PH_DIGITS: do_take = 1'b1;
        default: st.phase = a2u_pkg::PH_IDLE;
      endcase
    end

    if (num_first) begin
      if ((st.active_base == a2u_pkg::RADIX_AUTO || st.active_base == a2u_pkg::RADIX_HEX)
          && c == a2u_pkg::CH_ZERO) begin
        st.phase = a2u_pkg::PH_ZERO;
      end else begin
        if (st.active_base == a2u_pkg::RADIX_AUTO) st.active_base = a2u_pkg::RADIX_DEC;
        do_take = 1'b1;
      end
    end

    if (do_take) begin
      if (dig >= {1'b0, st.active_base}) begin
        emit_o   = 1'b1;
        st.phase = a2u_pkg::PH_IDLE;
      end else begin
        st.phase = a2u_pkg::PH_DIGITS;
        if (st.digit_status != a2u_pkg::DS_OVER) begin
          prod = a2u_pkg::PROD_W'(st.accumulator) * a2u_pkg::PROD_W'(st.active_base)
                 + a2u_pkg::PROD_W'(dig);
          if (prod[a2u_pkg::PROD_W-1:a2u_pkg::VALUE_WIDTH] != '0) begin
            st.digit_status = a2u_pkg::DS_OVER;
          end else begin
            st.accumulator  = prod[a2u_pkg::VALUE_WIDTH-1:0];
            st.digit_status = a2u_pkg::DS_SOME;
          end
        end
      end
    end

    if (st.digit_status == a2u_pkg::DS_OVER) begin
      v = '1;
    end else if (st.negative) begin
      v = '0 - st.accumulator;
    end else begin
      v = st.accumulator;
    end

    res_o.value      = a2u_pkg::OUT_W'(v);
    res_o.overflowed = (st.digit_status == a2u_pkg::DS_OVER);
    res_o.any_digits = (st.digit_status != a2u_pkg::DS_NONE);
    res_o.end_offset = (st.digit_status != a2u_pkg::DS_NONE) ? st.position : '0;

    state_o = st;
  end

endmodule

// File: rtl/a2u_outbuf.sv
// Two-entry result buffer between the parser and the output channel.
module a2u_outbuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  a2u_pkg::out_t data_i,
  output logic          full_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output a2u_pkg::out_t out_res_o
);

  logic [1:0]    cnt_q, cnt_d;
  a2u_pkg::out_t e0_q, e0_d;
  a2u_pkg::out_t e1_q, e1_d;
  logic          pop;

  assign pop         = (cnt_q != 2'd0) && !out_stall_i;
  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_res_o   = e0_q;

  always_comb begin
    e0_d  = e0_q;
    e1_d  = e1_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
    if (pop) begin
      if (cnt_q == 2'd2) begin
        e0_d = e1_q;
        if (push_i) e1_d = data_i;
      end else if (push_i) begin
        e0_d = data_i;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) e0_d = data_i;
      else e1_d = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

endmodule

// File: rtl/ascii_to_unsigned_parser_top.sv
// Top level of the streaming ASCII-to-unsigned parser.
//
//   channel  direction  payload   handshake
//   in       input      in_t      in_valid_i / in_stall_o
//   out      output     out_t     out_valid_o / out_stall_i
//
// One character per cycle when not stalled; a result is registered in the
// result buffer, formed from parse state and a single 32x6 multiply-add.
// Reset clears the parse state and empties the two-entry result buffer.
// in_stall_o rises only while both result entries wait to be taken.
module ascii_to_unsigned_parser_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  a2u_pkg::in_t  in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output a2u_pkg::out_t out_res_o
);

  a2u_pkg::state_t state_q, state_d;
  a2u_pkg::out_t   res;
  logic            emit;
  logic            accept;
  logic            full;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  a2u_step u_step (
    .state_i (state_q),
    .req_i   (in_req_i),
    .state_o (state_d),
    .emit_o  (emit),
    .res_o   (res)
  );

  a2u_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && emit),
    .data_i      (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase        <= a2u_pkg::PH_IDLE;
      state_q.negative     <= 1'b0;
      state_q.accumulator  <= '0;
      state_q.digit_status <= a2u_pkg::DS_NONE;
      state_q.active_base  <= '0;
      state_q.position     <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

endmodule
